// ----- hdl/bcdep_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bcdep_pkg: shared types and constants for the clock-register to epoch block
// Beat layouts, status codes, pipeline tags and calendar helpers.
// ----------------------------------------------------------------------------
package bcdep_pkg;

	localparam int unsigned YEAR_W     = 12;
	localparam int unsigned EPOCH_W    = 33;
	localparam int unsigned DAYS_W     = 17;
	localparam int unsigned TOD_W      = 17;
	localparam int unsigned DOE_W      = 18;
	localparam int unsigned PIPE_DEPTH = 5;

	localparam logic [YEAR_W-1:0] EARLIEST_YEAR_RST = 12'd2025;
	localparam logic [YEAR_W-1:0] BASE_1900         = 12'd1900;
	localparam logic [YEAR_W-1:0] BASE_2000         = 12'd2000;
	localparam logic [YEAR_W-1:0] ERA_START_1600    = 12'd1600;

	localparam logic [7:0] LOW_VOLT_BIT = 8'h80;
	localparam logic [7:0] MASK_7BIT    = 8'h7F;
	localparam logic [7:0] MASK_6BIT    = 8'h3F;
	localparam logic [7:0] MASK_5BIT    = 8'h1F;

	localparam logic [DOE_W-1:0] DAYS_PER_YEAR  = 18'd365;
	localparam logic [TOD_W-1:0] SECS_PER_HOUR  = 17'd3600;
	localparam logic [TOD_W-1:0] SECS_PER_MIN   = 17'd60;
	localparam logic signed [EPOCH_W-1:0] SECS_PER_DAY = 33'sd86400;

	// era * 146097 - 719468 for era 4 (1600..1999) and era 5 (2000..2399)
	localparam logic signed [18:0] ERA4_OFFSET = -19'sd135080;
	localparam logic signed [18:0] ERA5_OFFSET = 19'sd11017;

	typedef enum logic [1:0] {
		STATUS_OK          = 2'd0,
		STATUS_LOW_VOLTAGE = 2'd1,
		STATUS_IMPLAUSIBLE = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] seconds_reg;
		logic [7:0] minutes_reg;
		logic [7:0] hours_reg;
		logic [7:0] day_reg;
		logic [7:0] month_reg;
		logic [7:0] year_reg;
	} regs_t;

	typedef struct packed {
		logic signed [EPOCH_W-1:0] epoch_seconds;
		status_t                   status;
	} result_t;

	typedef struct packed {
		logic    valid;
		status_t status;
	} tag_t;

	typedef struct packed {
		logic [YEAR_W-1:0] year;
		logic [3:0]        month;
		logic [4:0]        day;
		logic [4:0]        hour;
		logic [5:0]        minute;
		logic [5:0]        second;
	} dec_t;

	function automatic logic [7:0] bcd_value(input logic [7:0] b);
		logic [7:0] tens;
		tens = {4'b0, b[7:4]};
		return (tens << 3) + (tens << 1) + {4'b0, b[3:0]};
	endfunction

	// days from March 1 to the first of the month, March-based year
	function automatic logic [8:0] month_offset(input logic [3:0] month);
		logic [8:0] r;
		case (month)
			4'd3:    r = 9'd0;
			4'd4:    r = 9'd31;
			4'd5:    r = 9'd61;
			4'd6:    r = 9'd92;
			4'd7:    r = 9'd122;
			4'd8:    r = 9'd153;
			4'd9:    r = 9'd184;
			4'd10:   r = 9'd214;
			4'd11:   r = 9'd245;
			4'd12:   r = 9'd275;
			4'd1:    r = 9'd306;
			4'd2:    r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/bcdep_decode.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bcdep_decode: register decode and plausibility stage
// Masks and BCD-decodes the six bytes, builds the status, registers into s1.
// ----------------------------------------------------------------------------
module bcdep_decode (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire bcdep_pkg::regs_t              regs,
	input  wire logic [bcdep_pkg::YEAR_W-1:0]  earliest_year,
	output bcdep_pkg::tag_t                    tag_s1,
	output bcdep_pkg::dec_t                    dec_s1
);

	logic [7:0]                     sec_v;
	logic [7:0]                     min_v;
	logic [7:0]                     hour_v;
	logic [7:0]                     day_v;
	logic [7:0]                     mon_v;
	logic [7:0]                     yy_v;
	logic [bcdep_pkg::YEAR_W-1:0]   year_v;
	logic                           bad;
	bcdep_pkg::status_t             status_v;

	always_comb begin
		sec_v  = bcdep_pkg::bcd_value(regs.seconds_reg & bcdep_pkg::MASK_7BIT);
		min_v  = bcdep_pkg::bcd_value(regs.minutes_reg & bcdep_pkg::MASK_7BIT);
		hour_v = bcdep_pkg::bcd_value(regs.hours_reg & bcdep_pkg::MASK_6BIT);
		day_v  = bcdep_pkg::bcd_value(regs.day_reg & bcdep_pkg::MASK_6BIT);
		mon_v  = bcdep_pkg::bcd_value(regs.month_reg & bcdep_pkg::MASK_5BIT);
		yy_v   = bcdep_pkg::bcd_value(regs.year_reg);
		year_v = ((regs.month_reg & bcdep_pkg::LOW_VOLT_BIT) != 8'h00 ?
			bcdep_pkg::BASE_1900 : bcdep_pkg::BASE_2000) + {4'b0, yy_v};
		bad = (year_v < earliest_year) || (yy_v > 8'd99) ||
			(mon_v < 8'd1) || (mon_v > 8'd12) || (day_v < 8'd1) || (day_v > 8'd31) ||
			(hour_v > 8'd23) || (min_v > 8'd59) || (sec_v > 8'd59);
		// low-voltage flag wins over every range check
		if ((regs.seconds_reg & bcdep_pkg::LOW_VOLT_BIT) != 8'h00) begin
			status_v = bcdep_pkg::STATUS_LOW_VOLTAGE;
		end else if (bad) begin
			status_v = bcdep_pkg::STATUS_IMPLAUSIBLE;
		end else begin
			status_v = bcdep_pkg::STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1.valid  <= 1'b0;
			tag_s1.status <= bcdep_pkg::STATUS_OK;
		end else begin
			tag_s1.valid  <= in_valid;
			tag_s1.status <= status_v;
		end
	end

	always_ff @(posedge clk) begin
		dec_s1.year   <= year_v;
		dec_s1.month  <= mon_v[3:0];
		dec_s1.day    <= day_v[4:0];
		dec_s1.hour   <= hour_v[4:0];
		dec_s1.minute <= min_v[5:0];
		dec_s1.second <= sec_v[5:0];
	end

endmodule
`default_nettype wire

// ----- hdl/bcdep_days.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bcdep_days: days-from-civil pipeline
// Three stages: era split and time of day, day of era, days since epoch.
// ----------------------------------------------------------------------------
module bcdep_days (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire bcdep_pkg::tag_t                      tag_s1,
	input  wire bcdep_pkg::dec_t                      dec_s1,
	output bcdep_pkg::tag_t                           tag_s4,
	output logic signed [bcdep_pkg::DAYS_W-1:0]       days_s4,
	output logic [bcdep_pkg::TOD_W-1:0]               tod_s4
);

	logic [bcdep_pkg::YEAR_W-1:0]  y_c;
	logic                          era5_c;
	logic [8:0]                    yoe_c;
	logic [8:0]                    doy_c;
	logic [bcdep_pkg::TOD_W-1:0]   tod_c;

	bcdep_pkg::tag_t               tag_s2;
	logic                          era5_s2;
	logic [8:0]                    yoe_s2;
	logic [8:0]                    doy_s2;
	logic [bcdep_pkg::TOD_W-1:0]   tod_s2;

	logic [1:0]                    cent_c;
	logic [bcdep_pkg::DOE_W-1:0]   doe_c;

	bcdep_pkg::tag_t               tag_s3;
	logic                          era5_s3;
	logic [bcdep_pkg::DOE_W-1:0]   doe_s3;
	logic [bcdep_pkg::TOD_W-1:0]   tod_s3;

	logic signed [18:0]            days_c;

	// stage 2: shift Jan/Feb into the previous year, split off the era
	always_comb begin
		y_c    = dec_s1.year - ((dec_s1.month <= 4'd2) ? 12'd1 : 12'd0);
		era5_c = (y_c >= bcdep_pkg::BASE_2000);
		yoe_c  = era5_c ? 9'(y_c - bcdep_pkg::BASE_2000) :
			9'(y_c - bcdep_pkg::ERA_START_1600);
		doy_c  = bcdep_pkg::month_offset(dec_s1.month) + {4'b0, dec_s1.day} - 9'd1;
		tod_c  = {12'b0, dec_s1.hour} * bcdep_pkg::SECS_PER_HOUR +
			{11'b0, dec_s1.minute} * bcdep_pkg::SECS_PER_MIN + {11'b0, dec_s1.second};
	end

	// stage 3: day of era
	always_comb begin
		if (yoe_s2 >= 9'd300) begin
			cent_c = 2'd3;
		end else if (yoe_s2 >= 9'd200) begin
			cent_c = 2'd2;
		end else if (yoe_s2 >= 9'd100) begin
			cent_c = 2'd1;
		end else begin
			cent_c = 2'd0;
		end
		doe_c = {9'b0, yoe_s2} * bcdep_pkg::DAYS_PER_YEAR + {11'b0, yoe_s2[8:2]} -
			{16'b0, cent_c} + {9'b0, doy_s2};
	end

	// stage 4: add the era base
	assign days_c = $signed({1'b0, doe_s3}) +
		(era5_s3 ? bcdep_pkg::ERA5_OFFSET : bcdep_pkg::ERA4_OFFSET);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2.valid  <= 1'b0;
			tag_s3.valid  <= 1'b0;
			tag_s4.valid  <= 1'b0;
			tag_s2.status <= bcdep_pkg::STATUS_OK;
			tag_s3.status <= bcdep_pkg::STATUS_OK;
			tag_s4.status <= bcdep_pkg::STATUS_OK;
		end else begin
			tag_s2.valid  <= tag_s1.valid;
			tag_s3.valid  <= tag_s2.valid;
			tag_s4.valid  <= tag_s3.valid;
			tag_s2.status <= tag_s1.status;
			tag_s3.status <= tag_s2.status;
			tag_s4.status <= tag_s3.status;
		end
	end

	always_ff @(posedge clk) begin
		era5_s2       <= era5_c;
		yoe_s2        <= yoe_c;
		doy_s2        <= doy_c;
		tod_s2        <= tod_c;

		era5_s3       <= era5_s2;
		doe_s3        <= doe_c;
		tod_s3        <= tod_s2;

		days_s4       <= days_c[bcdep_pkg::DAYS_W-1:0];
		tod_s4        <= tod_s3;
	end

endmodule
`default_nettype wire

// ----- hdl/bcdep_scale.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bcdep_scale: days to seconds and result register
// Scales days by the seconds in a day, adds the time of day, zeroes on error.
// ----------------------------------------------------------------------------
module bcdep_scale (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire bcdep_pkg::tag_t                      tag_s4,
	input  wire logic signed [bcdep_pkg::DAYS_W-1:0]  days_s4,
	input  wire logic [bcdep_pkg::TOD_W-1:0]          tod_s4,
	output logic                                      done,
	output bcdep_pkg::result_t                        result
);

	logic signed [bcdep_pkg::EPOCH_W-1:0] secs_c;
	logic                                 valid_s5;
	bcdep_pkg::result_t                   result_s5;

	assign secs_c = bcdep_pkg::EPOCH_W'(days_s4) * bcdep_pkg::SECS_PER_DAY +
		$signed({16'b0, tod_s4});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= tag_s4.valid;
		end
	end

	always_ff @(posedge clk) begin
		result_s5.status        <= tag_s4.status;
		result_s5.epoch_seconds <= (tag_s4.status == bcdep_pkg::STATUS_OK) ?
			secs_c : '0;
	end

	assign done   = valid_s5;
	assign result = result_s5;

endmodule
`default_nettype wire

// ----- hdl/bcd_clock_regs_to_epoch_core.sv -----
`default_nettype none
// A snapshot accepted with start passes through the stage registers s1 to s5 before it is on result, done high.
// Throughput: one snapshot per cycle; busy stays low, every stage advances each cycle.
// The datapath has five stages: decode, era split, day of era,
// epoch days, seconds scaling. The receiver cannot stall the result.
// Reset clears all valid bits and sets earliest_year back to 2025.
// ----------------------------------------------------------------------------
// bcd_clock_regs_to_epoch_core: clock register snapshot to Unix epoch seconds
// Top level: configuration register and the decode, day and scaling stages.
// ----------------------------------------------------------------------------
module bcd_clock_regs_to_epoch_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire bcdep_pkg::regs_t              regs,
	output logic                               done,
	output bcdep_pkg::result_t                 result,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [bcdep_pkg::YEAR_W-1:0]  cfg_data
);

	logic [bcdep_pkg::YEAR_W-1:0]          earliest_year_q;
	logic                                  in_valid;
	bcdep_pkg::tag_t                       tag_s1;
	bcdep_pkg::dec_t                       dec_s1;
	bcdep_pkg::tag_t                       tag_s4;
	logic signed [bcdep_pkg::DAYS_W-1:0]   days_s4;
	logic [bcdep_pkg::TOD_W-1:0]           tod_s4;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign in_valid  = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			earliest_year_q <= bcdep_pkg::EARLIEST_YEAR_RST;
		end else if (cfg_valid && cfg_ready) begin
			earliest_year_q <= cfg_data;
		end
	end

	bcdep_decode u_decode (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.regs          (regs),
		.earliest_year (earliest_year_q),
		.tag_s1        (tag_s1),
		.dec_s1        (dec_s1)
	);

	bcdep_days u_days (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_s1  (tag_s1),
		.dec_s1  (dec_s1),
		.tag_s4  (tag_s4),
		.days_s4 (days_s4),
		.tod_s4  (tod_s4)
	);

	bcdep_scale u_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_s4  (tag_s4),
		.days_s4 (days_s4),
		.tod_s4  (tod_s4),
		.done    (done),
		.result  (result)
	);

endmodule
`default_nettype wire

// ----- hdl/bcdep_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bcdep_checker: port-level checks for the epoch block
// Latency, status coding, zeroed epoch on error and no stall, seen from the ports.
// ----------------------------------------------------------------------------
module bcdep_checker (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic                busy,
	input  wire logic                done,
	input  wire bcdep_pkg::result_t  result,
	input  wire logic                cfg_valid,
	input  wire logic                cfg_ready
);

	// done is high exactly when an accepted beat has passed through the pipeline
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		($past(arst_n, 1) && $past(arst_n, 2) && $past(arst_n, 3) &&
		 $past(arst_n, 4) && $past(arst_n, 5)) |->
		(done == $past(start && !busy, bcdep_pkg::PIPE_DEPTH)))
		else $error("result strobe does not follow accepted beat");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != bcdep_pkg::STATUS_OK) |-> (result.epoch_seconds == '0))
		else $error("epoch not zero on error status");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.status == bcdep_pkg::STATUS_OK ||
			result.status == bcdep_pkg::STATUS_LOW_VOLTAGE ||
			result.status == bcdep_pkg::STATUS_IMPLAUSIBLE))
		else $error("undefined status code");

	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(start |-> !busy) and (cfg_valid |-> cfg_ready))
		else $error("block held off a beat");

endmodule

bind bcd_clock_regs_to_epoch_core bcdep_checker u_bcdep_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.result    (result),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);
`default_nettype wire
